// ===== rtl/core/ngp_pkg.sv =====
// Shared types, constants and the coordinate character step for the GGA parser.
`default_nettype none

package ngp_pkg;

    // Sentence limits
    localparam int MAX_SENTENCE = 128;
    localparam int LEN_W        = $clog2(MAX_SENTENCE + 1);

    localparam logic [6:0]  TOKEN_CAP   = 7'd64;
    localparam logic [23:0] MINUTES_CAP = 24'd9999999;
    localparam logic [29:0] LAT_CAP     = 30'd999999999;
    localparam logic [30:0] LON_CAP     = 31'd1999999999;
    localparam logic [5:0]  MIN_TOKENS_RESET = 6'd10;

    // Character codes
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_A      = 8'h41;

    // Token roles
    localparam logic [6:0] TOK_LAT = 7'd2;
    localparam logic [6:0] TOK_NS  = 7'd3;
    localparam logic [6:0] TOK_LON = 7'd4;
    localparam logic [6:0] TOK_EW  = 7'd5;

    localparam logic [3:0] LAT_DEG_LEN = 4'd2;
    localparam logic [3:0] LON_DEG_LEN = 4'd3;
    localparam logic [3:0] POS_CAP     = 4'd15;

    // Conversion: deg * 1e7 + (mins_e5 * 5 + 1) / 3, the divide by 3 as a reciprocal multiply
    localparam logic [23:0] DEG_E7       = 24'd10000000;
    localparam logic [26:0] RECIP3       = 27'd89478486;
    localparam int          RECIP3_SHIFT = 28;

    typedef struct packed {
        logic [9:0]  deg;
        logic [23:0] mins;
        logic        stopped;
        logic        dot;
        logic [2:0]  frac;
    } coord_state_t;

    // Closed sentence as it leaves the parser
    typedef struct packed {
        logic        fix_valid;
        logic [6:0]  lat_deg;
        logic [9:0]  lon_deg;
        logic [25:0] lat_x;
        logic [25:0] lon_x;
        logic [7:0]  ns;
        logic [7:0]  ew;
        logic [6:0]  tokens;
    } fix_entry_t;

    // After the multiply stage
    typedef struct packed {
        logic        fix_valid;
        logic [29:0] lat_deg_e7;
        logic [33:0] lon_deg_e7;
        logic [23:0] lat_q;
        logic [23:0] lon_q;
        logic [7:0]  ns;
        logic [7:0]  ew;
        logic [6:0]  tokens;
    } conv_stage_t;

    typedef struct packed {
        logic [29:0] lat;
        logic [30:0] lon;
        logic [7:0]  ns;
        logic [7:0]  ew;
    } fix_t;

    typedef struct packed {
        logic        fix_valid;
        fix_t        pos;
        logic [6:0]  tokens;
    } result_t;

    function automatic logic [13:0] frac_weight(input logic [2:0] idx);
        logic [13:0] w;
        case (idx)
            3'd1:    w = 14'd10000;
            3'd2:    w = 14'd1000;
            3'd3:    w = 14'd100;
            3'd4:    w = 14'd10;
            3'd5:    w = 14'd1;
            default: w = 14'd0;
        endcase
        return w;
    endfunction

    // One character of a coordinate token at position pos
    function automatic coord_state_t coord_step(input logic [7:0] c, input logic [3:0] pos,
                                                input logic [3:0] deg_len,
                                                input coord_state_t cur);
        coord_state_t r;
        logic         is_digit;
        logic [7:0]   dd;
        logic [3:0]   d;
        logic [26:0]  v;
        logic [2:0]   nf;
        r        = cur;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        dd       = c - CH_ZERO;
        d        = dd[3:0];
        v        = 27'd0;
        nf       = 3'd0;
        if (pos < deg_len) begin
            if (!cur.stopped) begin
                if (is_digit) begin
                    r.deg = 10'(cur.deg * 10'd10 + 10'(d));
                end else begin
                    r.stopped = 1'b1;
                end
            end
        end else if ({1'b0, pos} < ({1'b0, deg_len} + 5'd8)) begin
            if (pos == deg_len) begin
                r.stopped = 1'b0;
                r.dot     = 1'b0;
                r.frac    = 3'd0;
            end
            if (!r.stopped) begin
                if (is_digit) begin
                    if (!r.dot) begin
                        v = ({3'b0, cur.mins} * 27'd10) + (27'(d) * 27'd100000);
                    end else begin
                        nf     = (r.frac < 3'd7) ? r.frac + 3'd1 : 3'd7;
                        r.frac = nf;
                        v = {3'b0, cur.mins}
                          + ((nf <= 3'd5) ? (27'(d) * 27'(frac_weight(nf))) : 27'd0);
                    end
                    r.mins = (v > 27'(MINUTES_CAP)) ? MINUTES_CAP : v[23:0];
                end else if ((c == CH_DOT) && !r.dot) begin
                    r.dot = 1'b1;
                end else begin
                    r.stopped = 1'b1;
                end
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ngp_parser.sv =====
// Byte-level sentence tracker: window search, token counting and coordinate accumulation.
`default_nettype none

module ngp_parser (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               accept,
    input  wire logic [7:0]         rx_byte,
    input  wire logic [5:0]         min_tokens,
    output logic                    push,
    output ngp_pkg::fix_entry_t     entry
);

    logic [31:0] recent_reg, recent_next;
    logic        capturing_reg, capturing_next;
    logic [ngp_pkg::LEN_W-1:0] length_reg, length_next;
    logic [6:0]  tidx_reg, tidx_next;
    logic        inside_reg, inside_next;
    logic [3:0]  cp_reg, cp_next;
    logic        ps_reg, ps_next;
    logic        dot_reg, dot_next;
    logic [2:0]  fd_reg, fd_next;
    logic [6:0]  lat_deg_reg, lat_deg_next;
    logic [9:0]  lon_deg_reg, lon_deg_next;
    logic [23:0] lat_mins_reg, lat_mins_next;
    logic [23:0] lon_mins_reg, lon_mins_next;
    logic [7:0]  ns_reg, ns_next;
    logic [7:0]  ew_reg, ew_next;

    logic        window_hit;
    logic [6:0]  tidx_e;
    logic [6:0]  tok;
    logic [3:0]  cp_e;
    logic        ps_e, dot_e;
    logic [2:0]  fd_e;
    logic        tok_lat;
    ngp_pkg::coord_state_t cur, stp;

    assign window_hit = (rx_byte == ngp_pkg::CH_A) && (recent_reg[7:0] == ngp_pkg::CH_G)
                     && (recent_reg[23:16] == ngp_pkg::CH_N)
                     && (recent_reg[31:24] == ngp_pkg::CH_G);

    // Effective per-token state once a non-comma byte is seen
    always_comb begin
        if (inside_reg) begin
            tidx_e = tidx_reg;
            cp_e   = cp_reg;
            ps_e   = ps_reg;
            dot_e  = dot_reg;
            fd_e   = fd_reg;
        end else begin
            tidx_e = (tidx_reg < ngp_pkg::TOKEN_CAP) ? tidx_reg + 7'd1 : tidx_reg;
            cp_e   = 4'd0;
            ps_e   = 1'b0;
            dot_e  = 1'b0;
            fd_e   = 3'd0;
        end
        tok          = tidx_e - 7'd1;
        tok_lat      = (tok == ngp_pkg::TOK_LAT);
        cur.deg      = tok_lat ? {3'b0, lat_deg_reg} : lon_deg_reg;
        cur.mins     = tok_lat ? lat_mins_reg : lon_mins_reg;
        cur.stopped  = ps_e;
        cur.dot      = dot_e;
        cur.frac     = fd_e;
        stp = ngp_pkg::coord_step(rx_byte, cp_e,
                                  tok_lat ? ngp_pkg::LAT_DEG_LEN : ngp_pkg::LON_DEG_LEN, cur);
    end

    always_comb begin
        recent_next    = recent_reg;
        capturing_next = capturing_reg;
        length_next    = length_reg;
        tidx_next      = tidx_reg;
        inside_next    = inside_reg;
        cp_next        = cp_reg;
        ps_next        = ps_reg;
        dot_next       = dot_reg;
        fd_next        = fd_reg;
        lat_deg_next   = lat_deg_reg;
        lon_deg_next   = lon_deg_reg;
        lat_mins_next  = lat_mins_reg;
        lon_mins_next  = lon_mins_reg;
        ns_next        = ns_reg;
        ew_next        = ew_reg;
        push           = 1'b0;

        if (accept) begin
            recent_next = {recent_reg[23:0], rx_byte};
            if (capturing_reg) begin
                if (rx_byte == ngp_pkg::CH_DOLLAR) begin
                    capturing_next = 1'b0;
                    push           = 1'b1;
                end else if (length_reg >= ngp_pkg::LEN_W'(ngp_pkg::MAX_SENTENCE)) begin
                    // overlong: abandon, no result
                    capturing_next = 1'b0;
                end else begin
                    length_next = length_reg + ngp_pkg::LEN_W'(1);
                    if (rx_byte == ngp_pkg::CH_COMMA) begin
                        inside_next = 1'b0;
                    end else begin
                        inside_next = 1'b1;
                        tidx_next   = tidx_e;
                        cp_next     = (cp_e < ngp_pkg::POS_CAP) ? cp_e + 4'd1 : ngp_pkg::POS_CAP;
                        ps_next     = ps_e;
                        dot_next    = dot_e;
                        fd_next     = fd_e;
                        if ((tok == ngp_pkg::TOK_NS) && (cp_e == 4'd0)) begin
                            ns_next = rx_byte;
                        end
                        if ((tok == ngp_pkg::TOK_EW) && (cp_e == 4'd0)) begin
                            ew_next = rx_byte;
                        end
                        if (tok_lat) begin
                            lat_deg_next  = stp.deg[6:0];
                            lat_mins_next = stp.mins;
                            ps_next       = stp.stopped;
                            dot_next      = stp.dot;
                            fd_next       = stp.frac;
                        end else if (tok == ngp_pkg::TOK_LON) begin
                            lon_deg_next  = stp.deg;
                            lon_mins_next = stp.mins;
                            ps_next       = stp.stopped;
                            dot_next      = stp.dot;
                            fd_next       = stp.frac;
                        end
                    end
                end
            end else if (window_hit) begin
                // Open a sentence; the five window bytes form token 0, or tokens 0 and 1
                // when the wildcard byte is a comma.
                capturing_next = 1'b1;
                length_next    = ngp_pkg::LEN_W'(5);
                inside_next    = 1'b1;
                if (recent_reg[15:8] == ngp_pkg::CH_COMMA) begin
                    tidx_next = 7'd2;
                    cp_next   = 4'd2;
                end else begin
                    tidx_next = 7'd1;
                    cp_next   = 4'd5;
                end
                ps_next       = 1'b0;
                dot_next      = 1'b0;
                fd_next       = 3'd0;
                lat_deg_next  = 7'd0;
                lon_deg_next  = 10'd0;
                lat_mins_next = 24'd0;
                lon_mins_next = 24'd0;
                ns_next       = 8'd0;
                ew_next       = 8'd0;
            end
        end
    end

    always_comb begin
        entry.fix_valid = tidx_reg > {1'b0, min_tokens};
        entry.lat_deg   = lat_deg_reg;
        entry.lon_deg   = lon_deg_reg;
        entry.lat_x     = ({2'b0, lat_mins_reg} * 26'd5) + 26'd1;
        entry.lon_x     = ({2'b0, lon_mins_reg} * 26'd5) + 26'd1;
        entry.ns        = ns_reg;
        entry.ew        = ew_reg;
        entry.tokens    = tidx_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recent_reg    <= 32'd0;
            capturing_reg <= 1'b0;
            length_reg    <= '0;
            tidx_reg      <= 7'd0;
            inside_reg    <= 1'b0;
            cp_reg        <= 4'd0;
            ps_reg        <= 1'b0;
            dot_reg       <= 1'b0;
            fd_reg        <= 3'd0;
            lat_deg_reg   <= 7'd0;
            lon_deg_reg   <= 10'd0;
            lat_mins_reg  <= 24'd0;
            lon_mins_reg  <= 24'd0;
            ns_reg        <= 8'd0;
            ew_reg        <= 8'd0;
        end else begin
            recent_reg    <= recent_next;
            capturing_reg <= capturing_next;
            length_reg    <= length_next;
            tidx_reg      <= tidx_next;
            inside_reg    <= inside_next;
            cp_reg        <= cp_next;
            ps_reg        <= ps_next;
            dot_reg       <= dot_next;
            fd_reg        <= fd_next;
            lat_deg_reg   <= lat_deg_next;
            lon_deg_reg   <= lon_deg_next;
            lat_mins_reg  <= lat_mins_next;
            lon_mins_reg  <= lon_mins_next;
            ns_reg        <= ns_next;
            ew_reg        <= ew_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ngp_convert.sv =====
// Two-stage conversion of a closed sentence to 1e-7 degree positions with saturation.
`default_nettype none

module ngp_convert (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire ngp_pkg::fix_entry_t entry,
    input  wire logic                out_ready,
    output logic                     in_ready,
    output logic                     cand_valid,
    output ngp_pkg::result_t         cand
);

    logic                 a_valid_reg, a_valid_next;
    ngp_pkg::fix_entry_t  a_reg, a_next;
    logic                 b_valid_reg, b_valid_next;
    ngp_pkg::conv_stage_t b_reg, b_next;
    logic                 b_ready;
    logic [52:0]          lat_prod, lon_prod;
    logic [30:0]          lat_sum;
    logic [34:0]          lon_sum;

    assign b_ready  = !b_valid_reg || out_ready;
    assign in_ready = !a_valid_reg || b_ready;

    always_comb begin
        a_valid_next = a_valid_reg;
        a_next       = a_reg;
        if (in_ready) begin
            a_valid_next = push;
            if (push) begin
                a_next = entry;
            end
        end
    end

    // Multiply stage: degree scaling and divide-by-three by reciprocal
    always_comb begin
        lat_prod = {27'b0, a_reg.lat_x} * {26'b0, ngp_pkg::RECIP3};
        lon_prod = {27'b0, a_reg.lon_x} * {26'b0, ngp_pkg::RECIP3};
        b_valid_next = b_valid_reg;
        b_next       = b_reg;
        if (b_ready) begin
            b_valid_next = a_valid_reg;
            if (a_valid_reg) begin
                b_next.fix_valid  = a_reg.fix_valid;
                b_next.lat_deg_e7 = {23'b0, a_reg.lat_deg} * {6'b0, ngp_pkg::DEG_E7};
                b_next.lon_deg_e7 = {24'b0, a_reg.lon_deg} * {10'b0, ngp_pkg::DEG_E7};
                b_next.lat_q      = lat_prod[ngp_pkg::RECIP3_SHIFT+23:ngp_pkg::RECIP3_SHIFT];
                b_next.lon_q      = lon_prod[ngp_pkg::RECIP3_SHIFT+23:ngp_pkg::RECIP3_SHIFT];
                b_next.ns         = a_reg.ns;
                b_next.ew         = a_reg.ew;
                b_next.tokens     = a_reg.tokens;
            end
        end
    end

    // Add and saturate
    always_comb begin
        lat_sum = {1'b0, b_reg.lat_deg_e7} + {7'b0, b_reg.lat_q};
        lon_sum = {1'b0, b_reg.lon_deg_e7} + {11'b0, b_reg.lon_q};
        cand_valid     = b_valid_reg;
        cand.fix_valid = b_reg.fix_valid;
        cand.pos.lat   = (lat_sum > {1'b0, ngp_pkg::LAT_CAP}) ? ngp_pkg::LAT_CAP
                                                               : lat_sum[29:0];
        cand.pos.lon   = (lon_sum > {4'b0, ngp_pkg::LON_CAP}) ? ngp_pkg::LON_CAP
                                                               : lon_sum[30:0];
        cand.pos.ns    = b_reg.ns;
        cand.pos.ew    = b_reg.ew;
        cand.tokens    = b_reg.tokens;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg <= a_next;
        b_reg <= b_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/nmea_gga_position_parser.sv =====
// Top level of the GGA position parser: config register, parser, conversion and result register.
`default_nettype none

// Feed received characters on the s_ channel, one transfer per clock at full
// rate. A sentence opens on the byte window G N x G A and closes on the next
// '$'; that closing byte produces one result on the m_ channel (the closed
// sentence is captured in the first conversion stage at its transfer, the
// degree and divide-by-three multipliers fill the second stage, and the
// add and saturate feed the result register, which presents it).
// Every other byte produces no result.
// s_ready stays high every cycle unless the result register and both
// conversion stages are all holding results, which only a stalled m_ side can
// cause. Positions are magnitudes in 1e-7 degree; when fix_valid is low the
// position and hemisphere fields repeat the last valid fix (zero after reset)
// while token_total reports the current sentence. Write min_tokens through
// the cfg_ channel only while the block is idle; it is always ready.
module nmea_gga_position_parser (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_fix_valid,
    output logic [29:0]      m_latitude_e7,
    output logic [30:0]      m_longitude_e7,
    output logic [7:0]       m_ns_char,
    output logic [7:0]       m_ew_char,
    output logic [6:0]       m_token_total,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [5:0]  cfg_min_tokens
);

    logic [5:0]          min_tokens_reg, min_tokens_next;
    logic                m_valid_reg, m_valid_next;
    ngp_pkg::result_t    m_data_reg, m_data_next;
    ngp_pkg::fix_t       fix_reg, fix_next;

    logic                s_accept;
    logic                push;
    ngp_pkg::fix_entry_t entry;
    logic                conv_ready;
    logic                cand_valid;
    ngp_pkg::result_t    cand;
    logic                out_ready;
    logic                load;

    // Config register takes a write every cycle
    assign cfg_ready = 1'b1;
    assign min_tokens_next = (cfg_valid && cfg_ready) ? cfg_min_tokens : min_tokens_reg;

    assign s_ready  = conv_ready;
    assign s_accept = s_valid && s_ready;

    ngp_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (s_accept),
        .rx_byte    (s_rx_byte),
        .min_tokens (min_tokens_reg),
        .push       (push),
        .entry      (entry)
    );

    ngp_convert u_convert (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .entry      (entry),
        .out_ready  (out_ready),
        .in_ready   (conv_ready),
        .cand_valid (cand_valid),
        .cand       (cand)
    );

    // Result register; hold while stalled, advance on transfer
    assign out_ready = !m_valid_reg || m_ready;
    assign load      = cand_valid && out_ready;

    always_comb begin
        m_data_next  = m_data_reg;
        fix_next     = fix_reg;
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
            if (cand.fix_valid) begin
                // valid sentence: latch as the new fix
                fix_next    = cand.pos;
                m_data_next = cand;
            end else begin
                // invalid sentence: report the previous fix
                m_data_next.fix_valid = 1'b0;
                m_data_next.pos       = fix_reg;
                m_data_next.tokens    = cand.tokens;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_tokens_reg <= ngp_pkg::MIN_TOKENS_RESET;
            m_valid_reg    <= 1'b0;
            fix_reg        <= '0;
        end else begin
            min_tokens_reg <= min_tokens_next;
            m_valid_reg    <= m_valid_next;
            fix_reg        <= fix_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_fix_valid    = m_data_reg.fix_valid;
    assign m_latitude_e7  = m_data_reg.pos.lat;
    assign m_longitude_e7 = m_data_reg.pos.lon;
    assign m_ns_char      = m_data_reg.pos.ns;
    assign m_ew_char      = m_data_reg.pos.ew;
    assign m_token_total  = m_data_reg.tokens;

endmodule

`default_nettype wire

// ===== rtl/core/ngp_checker.sv =====
// Port-level checks for the GGA position parser, bound to the top level.
`default_nettype none

module ngp_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [7:0]  s_rx_byte,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic        m_fix_valid,
    input  wire logic [29:0] m_latitude_e7,
    input  wire logic [30:0] m_longitude_e7,
    input  wire logic [7:0]  m_ns_char,
    input  wire logic [7:0]  m_ew_char,
    input  wire logic [6:0]  m_token_total
);

    ngp_pkg::fix_t last_fix_reg;

    // Track the last valid fix seen on the result side
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_fix_reg <= '0;
        end else if (m_valid && m_ready && m_fix_valid) begin
            last_fix_reg <= {m_latitude_e7, m_longitude_e7, m_ns_char, m_ew_char};
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_fix_valid) && $stable(m_latitude_e7)
            && $stable(m_longitude_e7) && $stable(m_token_total))
        else $error("result changed while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && (s_rx_byte == ngp_pkg::CH_DOLLAR), 3))
        else $error("result appeared without a closing dollar three cycles earlier");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_fix_valid |-> (m_latitude_e7 == last_fix_reg.lat)
            && (m_longitude_e7 == last_fix_reg.lon) && (m_ns_char == last_fix_reg.ns)
            && (m_ew_char == last_fix_reg.ew))
        else $error("invalid result does not repeat the last fix");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_latitude_e7 <= ngp_pkg::LAT_CAP) && (m_longitude_e7 <= ngp_pkg::LON_CAP)
            && (m_token_total <= ngp_pkg::TOKEN_CAP))
        else $error("result field beyond its limit");

endmodule

bind nmea_gga_position_parser ngp_checker u_ngp_checker (.*);

`default_nettype wire

// ===== verif/nmea_gga_position_parser_test.sv =====
// Self-checking testbench for the GGA position parser: byte stream in, fixes checked field by field.
module nmea_gga_position_parser_test;

    // One fix as the result channel should present it
    typedef struct packed {
        logic        fix_valid;
        logic [29:0] lat;
        logic [30:0] lon;
        logic [7:0]  ns;
        logic [7:0]  ew;
        logic [6:0]  tokens;
    } gga_fix_t;

    logic        aclk;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte      = 8'h00;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic        m_fix_valid;
    logic [29:0] m_latitude_e7;
    logic [30:0] m_longitude_e7;
    logic [7:0]  m_ns_char;
    logic [7:0]  m_ew_char;
    logic [6:0]  m_token_total;
    logic        cfg_valid      = 1'b0;
    logic        cfg_ready;
    logic [5:0]  cfg_min_tokens = 6'd0;

    nmea_gga_position_parser dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_fix_valid    (m_fix_valid),
        .m_latitude_e7  (m_latitude_e7),
        .m_longitude_e7 (m_longitude_e7),
        .m_ns_char      (m_ns_char),
        .m_ew_char      (m_ew_char),
        .m_token_total  (m_token_total),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_min_tokens (cfg_min_tokens)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case a transfer never completes
    initial begin
        #3000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Traffic control and bookkeeping
    // ------------------------------------------------------------------
    logic [7:0] rx_backlog[$];       // characters waiting for the input channel
    gga_fix_t   expected_fixes[$];   // fixes predicted but not yet seen
    gga_fix_t   want_fix;
    int         send_idle_pct = 0;
    int         stall_pct     = 0;
    bit         hold_sender   = 1'b0;
    int         chars_queued  = 0;
    int         error_count   = 0;
    int         fixes_seen    = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < 200)
            $display("mismatch in %s: got %0d, expected %0d (fix %0d)",
                     what, got, want, fixes_seen);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Sentence tracker: mirrors the parser state one character at a time
    // ------------------------------------------------------------------
    logic [5:0]  min_tokens_cfg;
    logic [31:0] window_bytes;
    logic        in_sentence;
    logic [7:0]  sentence_len;
    logic [6:0]  token_count;
    logic        in_token;
    logic [3:0]  char_pos;
    logic        coord_stopped;
    logic        coord_dot;
    logic [2:0]  frac_count;
    logic [6:0]  lat_deg;
    logic [9:0]  lon_deg;
    logic [23:0] lat_min_e5;
    logic [23:0] lon_min_e5;
    logic [7:0]  ns_pending;
    logic [7:0]  ew_pending;
    logic [29:0] last_lat;
    logic [30:0] last_lon;
    logic [7:0]  last_ns;
    logic [7:0]  last_ew;

    task automatic open_sentence();
        in_sentence   = 1'b1;
        sentence_len  = 8'd0;
        token_count   = 7'd0;
        in_token      = 1'b0;
        char_pos      = 4'd0;
        coord_stopped = 1'b0;
        coord_dot     = 1'b0;
        frac_count    = 3'd0;
        lat_deg       = 7'd0;
        lon_deg       = 10'd0;
        lat_min_e5    = 24'd0;
        lon_min_e5    = 24'd0;
        ns_pending    = 8'd0;
        ew_pending    = 8'd0;
    endtask

    task automatic clear_tracker();
        open_sentence();
        in_sentence    = 1'b0;
        min_tokens_cfg = ngp_pkg::MIN_TOKENS_RESET;
        window_bytes   = 32'd0;
        last_lat       = 30'd0;
        last_lon       = 31'd0;
        last_ns        = 8'd0;
        last_ew        = 8'd0;
    endtask

    // Accumulate one character of a latitude or longitude token
    task automatic coord_char(input logic [7:0] c, input logic [3:0] pos, input bit is_lon);
        int          deg_len;
        logic [9:0]  deg;
        logic [23:0] mins;
        logic [63:0] mv;
        logic [63:0] dv;
        logic [63:0] v;
        logic        is_digit;
        deg_len  = is_lon ? int'(ngp_pkg::LON_DEG_LEN) : int'(ngp_pkg::LAT_DEG_LEN);
        deg      = is_lon ? lon_deg : {3'b000, lat_deg};
        mins     = is_lon ? lon_min_e5 : lat_min_e5;
        is_digit = (c >= ngp_pkg::CH_ZERO) && (c <= ngp_pkg::CH_NINE);
        dv       = {60'd0, c[3:0]};
        if (int'(pos) < deg_len) begin
            // degree digits: first non-digit freezes the value
            if (!coord_stopped) begin
                if (is_digit)
                    deg = deg * 10'd10 + dv[9:0];
                else
                    coord_stopped = 1'b1;
            end
        end else if (int'(pos) < deg_len + 8) begin
            if (int'(pos) == deg_len) begin
                coord_stopped = 1'b0;
                coord_dot     = 1'b0;
                frac_count    = 3'd0;
            end
            if (!coord_stopped) begin
                if (is_digit) begin
                    mv = {40'd0, mins};
                    if (!coord_dot) begin
                        v = mv * 64'd10 + dv * 64'd100000;
                    end else begin
                        if (frac_count < 3'd7)
                            frac_count = frac_count + 3'd1;
                        case (frac_count)
                            3'd1:    v = mv + dv * 64'd10000;
                            3'd2:    v = mv + dv * 64'd1000;
                            3'd3:    v = mv + dv * 64'd100;
                            3'd4:    v = mv + dv * 64'd10;
                            3'd5:    v = mv + dv;
                            default: v = mv;
                        endcase
                    end
                    mins = (v > {40'd0, ngp_pkg::MINUTES_CAP}) ? ngp_pkg::MINUTES_CAP
                                                               : v[23:0];
                end else if (c == ngp_pkg::CH_DOT && !coord_dot) begin
                    coord_dot = 1'b1;
                end else begin
                    coord_stopped = 1'b1;
                end
            end
        end
        if (is_lon) begin
            lon_deg    = deg;
            lon_min_e5 = mins;
        end else begin
            lat_deg    = deg[6:0];
            lat_min_e5 = mins;
        end
    endtask

    // Tokenize like strtok: commas separate, empty tokens never count
    task automatic feed_char(input logic [7:0] c);
        logic [6:0] tok;
        logic [3:0] pos;
        if (c == ngp_pkg::CH_COMMA) begin
            in_token = 1'b0;
        end else begin
            if (!in_token) begin
                if (token_count < ngp_pkg::TOKEN_CAP)
                    token_count = token_count + 7'd1;
                in_token      = 1'b1;
                char_pos      = 4'd0;
                coord_stopped = 1'b0;
                coord_dot     = 1'b0;
                frac_count    = 3'd0;
            end
            tok = token_count - 7'd1;
            pos = char_pos;
            if (tok == ngp_pkg::TOK_NS && pos == 4'd0)
                ns_pending = c;
            if (tok == ngp_pkg::TOK_EW && pos == 4'd0)
                ew_pending = c;
            if (tok == ngp_pkg::TOK_LAT)
                coord_char(c, pos, 1'b0);
            if (tok == ngp_pkg::TOK_LON)
                coord_char(c, pos, 1'b1);
            if (char_pos < ngp_pkg::POS_CAP)
                char_pos = char_pos + 4'd1;
        end
    endtask

    function automatic logic [30:0] degrees_e7(input logic [9:0] deg, input logic [23:0] mins,
                                               input logic [30:0] cap);
        logic [63:0] dv;
        logic [63:0] mv;
        logic [63:0] v;
        dv = {54'd0, deg};
        mv = {40'd0, mins};
        v  = dv * 64'd10000000 + (mv * 64'd5 + 64'd1) / 64'd3;
        return (v > {33'd0, cap}) ? cap : v[30:0];
    endfunction

    // Advance the tracker by one accepted character; a closing '$' yields a fix
    task automatic track_rx_char(input logic [7:0] c);
        logic [31:0] prev;
        logic [30:0] lat_wide;
        gga_fix_t    fix;
        prev         = window_bytes;
        window_bytes = {window_bytes[23:0], c};
        if (in_sentence) begin
            if (c == ngp_pkg::CH_DOLLAR) begin
                fix.fix_valid = token_count > {1'b0, min_tokens_cfg};
                if (fix.fix_valid) begin
                    lat_wide = degrees_e7({3'b000, lat_deg}, lat_min_e5,
                                          {1'b0, ngp_pkg::LAT_CAP});
                    last_lat = lat_wide[29:0];
                    last_lon = degrees_e7(lon_deg, lon_min_e5, ngp_pkg::LON_CAP);
                    last_ns  = ns_pending;
                    last_ew  = ew_pending;
                end
                fix.lat    = last_lat;
                fix.lon    = last_lon;
                fix.ns     = last_ns;
                fix.ew     = last_ew;
                fix.tokens = token_count;
                expected_fixes.push_back(fix);
                in_sentence = 1'b0;
            end else if (sentence_len >= ngp_pkg::MAX_SENTENCE) begin
                // drop an overlong sentence and go back to scanning
                in_sentence = 1'b0;
            end else begin
                sentence_len = sentence_len + 8'd1;
                feed_char(c);
            end
        end else if (c == ngp_pkg::CH_A && prev[7:0] == ngp_pkg::CH_G &&
                     prev[23:16] == ngp_pkg::CH_N && prev[31:24] == ngp_pkg::CH_G) begin
            open_sentence();
            feed_char(ngp_pkg::CH_G);
            feed_char(ngp_pkg::CH_N);
            feed_char(prev[15:8]);
            feed_char(ngp_pkg::CH_G);
            feed_char(ngp_pkg::CH_A);
            sentence_len = 8'd5;
        end
    endtask

    // ------------------------------------------------------------------
    // Input driver: pull characters from the backlog, hold until transfer
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                track_rx_char(s_rx_byte);
            // only move on once the current character has transferred
            if (!s_valid || s_ready) begin
                if (rx_backlog.size() != 0 && !hold_sender &&
                    $urandom_range(99) >= send_idle_pct) begin
                    s_valid   <= 1'b1;
                    s_rx_byte <= rx_backlog.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each transfer with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_fixes.size() == 0) begin
                    report_mismatch("unexpected fix", 32'd1, 32'd0);
                end else begin
                    want_fix = expected_fixes.pop_front();
                    if (m_fix_valid !== want_fix.fix_valid)
                        report_mismatch("fix_valid", 32'(m_fix_valid),
                                        32'(want_fix.fix_valid));
                    if (m_latitude_e7 !== want_fix.lat)
                        report_mismatch("latitude_e7", 32'(m_latitude_e7), 32'(want_fix.lat));
                    if (m_longitude_e7 !== want_fix.lon)
                        report_mismatch("longitude_e7", 32'(m_longitude_e7),
                                        32'(want_fix.lon));
                    if (m_ns_char !== want_fix.ns)
                        report_mismatch("ns_char", 32'(m_ns_char), 32'(want_fix.ns));
                    if (m_ew_char !== want_fix.ew)
                        report_mismatch("ew_char", 32'(m_ew_char), 32'(want_fix.ew));
                    if (m_token_total !== want_fix.tokens)
                        report_mismatch("token_total", 32'(m_token_total),
                                        32'(want_fix.tokens));
                end
                fixes_seen++;
            end
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic queue_char(input logic [7:0] c);
        rx_backlog.push_back(c);
        chars_queued++;
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            queue_char(s[i]);
    endtask

    function automatic logic [7:0] any_digit();
        logic [7:0] d;
        d = 8'($urandom_range(9));
        return ngp_pkg::CH_ZERO + d;
    endfunction

    // Any byte that neither separates tokens nor ends the sentence
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        while (c == ngp_pkg::CH_COMMA || c == ngp_pkg::CH_DOLLAR)
            c = 8'($urandom_range(255));
        return c;
    endfunction

    // Run of one-character tokens, used to reach the length and token limits
    task automatic queue_token_run(input int pairs, input bit split_window);
        queue_char(ngp_pkg::CH_DOLLAR);
        queue_char(ngp_pkg::CH_G);
        queue_char(ngp_pkg::CH_N);
        queue_char(split_window ? ngp_pkg::CH_COMMA : ngp_pkg::CH_G);
        queue_char(ngp_pkg::CH_G);
        queue_char(ngp_pkg::CH_A);
        repeat (pairs) begin
            queue_char(ngp_pkg::CH_COMMA);
            queue_char(plain_char());
        end
    endtask

    task automatic queue_coord(input int deg_len);
        int r;
        bit nines;
        r     = $urandom_range(99);
        nines = (r < 15);   // drive toward minute and position saturation
        if (r >= 8) begin
            repeat (deg_len) begin
                if (nines)
                    queue_char(ngp_pkg::CH_NINE);
                else if ($urandom_range(24) == 0)
                    queue_char(plain_char());
                else
                    queue_char(any_digit());
            end
            repeat ($urandom_range(0, 4))
                queue_char(nines ? ngp_pkg::CH_NINE : any_digit());
            if ($urandom_range(3) != 0) begin
                queue_char(ngp_pkg::CH_DOT);
                repeat ($urandom_range(0, 8))
                    queue_char(nines ? ngp_pkg::CH_NINE : any_digit());
            end
            if ($urandom_range(7) == 0)
                queue_char(plain_char());
            if ($urandom_range(11) == 0)
                queue_char(ngp_pkg::CH_DOT);
            if ($urandom_range(5) == 0)
                repeat ($urandom_range(1, 6))
                    queue_char(any_digit());
        end
    endtask

    task automatic queue_hemisphere(input logic [7:0] first, input logic [7:0] second);
        int r;
        r = $urandom_range(9);
        if (r >= 6) begin
            repeat ($urandom_range(1, 3))
                queue_char(plain_char());
        end else if (r != 0) begin
            queue_char(r[0] ? first : second);
        end
    endtask

    task automatic queue_filler();
        int r;
        r = $urandom_range(9);
        if (r == 9) begin
            // raw bytes: may end the sentence early with a stray '$'
            repeat ($urandom_range(1, 4))
                queue_char(8'($urandom_range(255)));
        end else if (r >= 2) begin
            repeat ($urandom_range(1, 4))
                queue_char(any_digit());
        end
    endtask

    task automatic queue_gga_sentence();
        int shape;
        shape = $urandom_range(99);
        if (shape < 8) begin
            queue_token_run($urandom_range(58, 63), 1'($urandom_range(1)));
        end else begin
            queue_char(ngp_pkg::CH_DOLLAR);
            queue_char(ngp_pkg::CH_G);
            queue_char(ngp_pkg::CH_N);
            if ($urandom_range(9) == 0)
                queue_char(8'($urandom_range(255)));
            else
                queue_char(ngp_pkg::CH_G);
            queue_char(ngp_pkg::CH_G);
            queue_char(ngp_pkg::CH_A);
            queue_char(ngp_pkg::CH_COMMA);
            if ($urandom_range(7) != 0)
                repeat (6) queue_char(any_digit());
            queue_char(ngp_pkg::CH_COMMA);
            queue_coord(int'(ngp_pkg::LAT_DEG_LEN));
            queue_char(ngp_pkg::CH_COMMA);
            queue_hemisphere("N", "S");
            queue_char(ngp_pkg::CH_COMMA);
            queue_coord(int'(ngp_pkg::LON_DEG_LEN));
            queue_char(ngp_pkg::CH_COMMA);
            queue_hemisphere("E", "W");
            repeat ($urandom_range(0, 9)) begin
                queue_char(ngp_pkg::CH_COMMA);
                queue_filler();
            end
            if ($urandom_range(1) == 1)
                queue_text("*5A\r\n");
        end
        // line noise between sentences, possibly forming partial windows
        if ($urandom_range(6) == 0)
            repeat ($urandom_range(1, 6))
                queue_char(8'($urandom_range(255)));
    endtask

    task automatic queue_directed();
        queue_text("$$");                                        // '$' with no sentence open
        queue_text("$GPGGA,1,2,3,4,5,6,7,8,9,10,11,12");         // talker mismatch: no window
        queue_text("$GNGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47\r\n");
        queue_text("$GNGGA,235959.99,9999.99999999,S,99999.99999999,W,2,12,0.5,9,M,,M,,*00\r\n");
        queue_text("$GNGGA,000000,0000.00000,N,00000.00000,E,1,01,1.0,0.0,M,0.0,M,,*00\r\n");
        queue_text("$GNGGA,,,,,,,1,2,3,4,5,6,7,8,9,10,11\r\n"); // empty tokens skipped
        queue_text("$GN,GA,1234.5,N,12345.6,E,a,b,c,d,e,f\r\n"); // comma in the wildcard
        queue_text("$GN$GA,2233.44,S,01122.33,W,a,b,c,d,e,f,g\r\n");
        queue_text("$GNGGA,1,GNGGA,5,GNGGA,6,7,8,9,10,11,12\r\n");
        queue_text("$GNGGA,t,4A07.5,N,1B207.5,E,x,y,z,u,v,w\r\n");
        queue_text("$GNGGA,t,4507.1.5,N,12307.1234567,E,x,y,z,u,v,w\r\n");
        queue_text("$GNGGA,t,4507123456789,N,123.07,E,x,y,z,u,v,w\r\n");
        queue_text("$GNGGA,t,12\r\n");                          // too few tokens: old fix
        // control characters inside tokens
        queue_text("$GNGGA,");
        queue_char(8'h00);
        queue_text(",40");
        queue_char(8'h01);
        queue_text("0.5,");
        queue_char(8'h7F);
        queue_text(",0123.4,");
        queue_char(8'hFF);
        queue_text(",a,b,c,d,e,f,g");
        // exactly at the length limit with 63 tokens, then one byte too many
        queue_token_run(61, 1'b1);
        queue_char(ngp_pkg::CH_COMMA);
        queue_token_run(62, 1'b0);
        queue_text("$GNGGA,1,5130.5,N,00007.5,W,1,2,3,4,5,6,7");
        queue_char(ngp_pkg::CH_DOLLAR);
    endtask

    // ------------------------------------------------------------------
    // Phase sequencing
    // ------------------------------------------------------------------
    // Wait until every character has transferred and every fix has arrived,
    // then let the conversion pipeline settle
    task automatic wait_quiet(input int limit);
        int waited;
        waited = 0;
        @(negedge aclk);
        while ((rx_backlog.size() != 0 || s_valid || expected_fixes.size() != 0) &&
               waited < limit) begin
            @(negedge aclk);
            waited++;
        end
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_min_tokens(input logic [5:0] value);
        @(posedge aclk);
        cfg_valid      <= 1'b1;
        cfg_min_tokens <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        min_tokens_cfg = value;
        cfg_valid      <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic run_phase(input logic [5:0] min_tokens, input int send_pct,
                             input int recv_pct, input bit drain_midway);
        int start;
        int sentences;
        int half;
        wait_quiet(20000);
        write_min_tokens(min_tokens);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
        start         = chars_queued;
        sentences     = 0;
        while (chars_queued - start < 100 || sentences < 2) begin
            queue_gga_sentence();
            sentences++;
        end
        queue_char(ngp_pkg::CH_DOLLAR);       // close the last sentence
        if (drain_midway) begin
            // hold the sender halfway until the result side has caught up
            half = rx_backlog.size() / 2;
            while (rx_backlog.size() > half)
                @(negedge aclk);
            hold_sender = 1'b1;
            @(negedge aclk);
            while (s_valid || expected_fixes.size() != 0)
                @(negedge aclk);
            hold_sender = 1'b0;
        end
    endtask

    initial begin
        logic [5:0] mid_tokens;
        clear_tracker();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        queue_directed();
        run_phase(6'd0, 0, 0, 1'b0);
        run_phase(6'd63, 62, 0, 1'b0);
        run_phase(6'd62, 0, 62, 1'b0);
        mid_tokens = 6'($urandom_range(14));
        run_phase(mid_tokens, 30, 30, 1'b1);
        run_phase(6'd5, 0, 0, 1'b0);
        run_phase(ngp_pkg::MIN_TOKENS_RESET, 62, 0, 1'b0);
        wait_quiet(20000);
        if (expected_fixes.size() != 0)
            report_mismatch("fixes never delivered", 32'd0, 32'(expected_fixes.size()));
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/ngp_pkg.sv
rtl/core/ngp_parser.sv
rtl/core/ngp_convert.sv
rtl/core/nmea_gga_position_parser.sv
rtl/core/ngp_checker.sv
verif/nmea_gga_position_parser_test.sv
